### src/tgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tap gesture decoder package
// Shared word types, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
package tgd_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TIME_W      = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_TAP_WINDOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD     = 2'd1;

	localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 16'd300;
	localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 16'd80;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_LEFT  = 2'd1;
	localparam logic [1:0] EV_RIGHT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WAIT  = 2'd1,
		ST_LEFT  = 2'd2,
		ST_RIGHT = 2'd3
	} gesture_state_t;

	typedef struct packed {
		logic              move_button;
		logic              fire_button;
		logic [TIME_W-1:0] time_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0] move_event;
		logic       fire_event;
	} out_word_t;

endpackage
`default_nettype wire

### src/tgd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tap gesture decoder core
// Holds the gesture state and the edge history, and decodes one sample.
// ----------------------------------------------------------------------------
module tgd_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire tgd_pkg::in_word_t               sample,
	input  wire logic [tgd_pkg::CFG_DATA_W-1:0]  window,
	input  wire logic [tgd_pkg::CFG_DATA_W-1:0]  period,
	output tgd_pkg::out_word_t                   result
);
	import tgd_pkg::*;

	gesture_state_t      state_q;
	gesture_state_t      state_d;
	logic [TIME_W-1:0]   first_tap_time_q;
	logic [TIME_W-1:0]   last_move_time_q;
	logic                move_prev_q;
	logic                fire_prev_q;
	logic                mv_rise;
	logic                timeout;
	logic                repeat_due;
	logic [TIME_W-1:0]   tap_elapsed;
	logic [TIME_W-1:0]   move_elapsed;
	logic                set_first;
	logic                set_last;
	logic [1:0]          ev;

	assign mv_rise      = sample.move_button & ~move_prev_q;
	assign tap_elapsed  = sample.time_ms - first_tap_time_q;
	assign move_elapsed = sample.time_ms - last_move_time_q;
	assign timeout      = tap_elapsed > {{(TIME_W-CFG_DATA_W){1'b0}}, window};
	assign repeat_due   = move_elapsed >= {{(TIME_W-CFG_DATA_W){1'b0}}, period};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (mv_rise) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (mv_rise) begin
					state_d = ST_RIGHT;
				end else if (timeout) begin
					state_d = sample.move_button ? ST_LEFT : ST_IDLE;
				end
			end
			ST_LEFT, ST_RIGHT: begin
				if (!sample.move_button) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ev        = EV_NONE;
		set_first = 1'b0;
		set_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				set_first = mv_rise;
			end
			ST_WAIT: begin
				if (mv_rise) begin
					ev       = EV_RIGHT;
					set_last = 1'b1;
				end else if (timeout) begin
					ev       = EV_LEFT;
					set_last = 1'b1;
				end
			end
			ST_LEFT, ST_RIGHT: begin
				if (sample.move_button && repeat_due) begin
					ev       = (state_q == ST_LEFT) ? EV_LEFT : EV_RIGHT;
					set_last = 1'b1;
				end
			end
			default: begin
				ev = EV_NONE;
			end
		endcase
	end

	assign result.move_event = ev;
	assign result.fire_event = sample.fire_button & ~fire_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			first_tap_time_q <= '0;
			last_move_time_q <= '0;
			move_prev_q      <= 1'b0;
			fire_prev_q      <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			move_prev_q <= sample.move_button;
			fire_prev_q <= sample.fire_button;
			if (set_first) begin
				first_tap_time_q <= sample.time_ms;
			end
			if (set_last) begin
				last_move_time_q <= sample.time_ms;
			end
		end
	end

endmodule
`default_nettype wire

### src/tap_gesture_decoder_autorepeat_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tap gesture decoder with autorepeat
// Decodes double taps, holds and fire presses from sampled button levels.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. A word is registered on
// entry, decoded by the gesture state machine and placed in the output
// register, and a new word is taken every clock while the output side keeps
// up. The gesture state and the two timestamps are updated as each word is
// decoded, which sets that rate. Configuration writes are always ready and
// take effect on the next decoded word.
module tap_gesture_decoder_autorepeat_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire tgd_pkg::in_word_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output tgd_pkg::out_word_t                    out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tgd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tgd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tgd_pkg::*;

	logic                  valid_s1;
	in_word_t              data_s1;
	logic                  out_valid_q;
	out_word_t             out_data_q;
	out_word_t             result;
	logic                  advance;
	logic [CFG_DATA_W-1:0] window_q;
	logic [CFG_DATA_W-1:0] period_q;

	assign advance   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DOUBLE_TAP_WINDOW) begin
				window_q <= cfg_data;
			end else if (cfg_index == REG_REPEAT_PERIOD) begin
				period_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	tgd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (data_s1),
		.window (window_q),
		.period (period_q),
		.result (result)
	);

`ifndef ASSERT_OFF
	a_no_bad_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.move_event != 2'd3))
		else $error("Output word carries an undefined move event.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("Input stalled without a blocked output word.");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("Decoded word did not reach the output register.");
`endif

endmodule
`default_nettype wire

### dv/tap_gesture_decoder_autorepeat_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap gesture decoder testbench
// Drives button samples through the decoder with random idling and stalls and
// checks every output word against a cycle-free model of the gesture logic.
// Directed gestures and register extremes come first, then a long receiver
// hold-off, then random gesture sequences under several idling and stall mixes.
// ----------------------------------------------------------------------------
module tap_gesture_decoder_autorepeat_top_tb;
	import tgd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1000;
	localparam int SETTLE_CYCLES = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	in_word_t               in_data   = '0;
	logic                   out_stall = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_stall;
	logic                   out_valid;
	out_word_t              out_data;
	logic                   cfg_ready;

	gesture_state_t         pred_state      = ST_IDLE;
	logic [TIME_W-1:0]      pred_tap_time   = '0;
	logic [TIME_W-1:0]      pred_move_time  = '0;
	logic                   pred_move_prev  = 1'b0;
	logic                   pred_fire_prev  = 1'b0;
	logic [CFG_DATA_W-1:0]  pred_window     = WINDOW_RESET;
	logic [CFG_DATA_W-1:0]  pred_period     = PERIOD_RESET;

	out_word_t              expected_events[$];
	int                     error_count   = 0;
	int                     items_sent    = 0;
	int                     send_idle_pct = 0;
	int                     stall_pct     = 0;
	int                     hold_requests = 0;
	int                     hold_seen     = 0;
	int                     hold_left     = 0;
	int                     cycle_count;
	logic [TIME_W-1:0]      sample_time   = '0;

	always #4 clk = ~clk;

	tap_gesture_decoder_autorepeat_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic out_word_t predict_gesture(input in_word_t w);
		out_word_t         r;
		logic              move_rise;
		logic [TIME_W-1:0] since_tap;
		logic [TIME_W-1:0] since_move;
		move_rise    = w.move_button && !pred_move_prev;
		r.fire_event = w.fire_button && !pred_fire_prev;
		r.move_event = EV_NONE;
		since_tap    = w.time_ms - pred_tap_time;
		since_move   = w.time_ms - pred_move_time;
		case (pred_state)
			ST_IDLE: begin
				if (move_rise) begin
					pred_state    = ST_WAIT;
					pred_tap_time = w.time_ms;
				end
			end
			ST_WAIT: begin
				if (move_rise) begin
					r.move_event   = EV_RIGHT;
					pred_move_time = w.time_ms;
					pred_state     = ST_RIGHT;
				end else if (since_tap > TIME_W'(pred_window)) begin
					r.move_event   = EV_LEFT;
					pred_move_time = w.time_ms;
					pred_state     = w.move_button ? ST_LEFT : ST_IDLE;
				end
			end
			default: begin
				if (!w.move_button) begin
					pred_state = ST_IDLE;
				end else if (since_move >= TIME_W'(pred_period)) begin
					r.move_event   = (pred_state == ST_LEFT) ? EV_LEFT : EV_RIGHT;
					pred_move_time = w.time_ms;
				end
			end
		endcase
		pred_move_prev = w.move_button;
		pred_fire_prev = w.fire_button;
		return r;
	endfunction

	task automatic send_sample(input logic mv, input logic fr, input logic [TIME_W-1:0] t);
		in_word_t w;
		w.move_button = mv;
		w.fire_button = fr;
		w.time_ms     = t;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_stall);
		expected_events.push_back(predict_gesture(w));
		items_sent++;
	endtask

	task automatic tick_sample(input logic mv, input logic [TIME_W-1:0] delta);
		sample_time += delta;
		send_sample(mv, 1'($urandom_range(1)), sample_time);
	endtask

	task automatic drain_events();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (index == REG_DOUBLE_TAP_WINDOW) begin
			pred_window = value;
		end else if (index == REG_REPEAT_PERIOD) begin
			pred_period = value;
		end
	endtask

	function automatic logic [TIME_W-1:0] near(input logic [TIME_W-1:0] base);
		return base + TIME_W'($urandom_range(2)) - TIME_W'(1);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_setting();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return CFG_DATA_W'($urandom_range(1, 20));
			3: return CFG_DATA_W'($urandom_range(50, 400));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				$error("unexpected output word: move_event %0d fire_event %0d",
					out_data.move_event, out_data.fire_event);
				error_count++;
			end else begin
				if (out_data.move_event !== expected_events[0].move_event) begin
					$error("move_event mismatch: expected %0d, actual %0d",
						expected_events[0].move_event, out_data.move_event);
					error_count++;
				end
				if (out_data.fire_event !== expected_events[0].fire_event) begin
					$error("fire_event mismatch: expected %0d, actual %0d",
						expected_events[0].fire_event, out_data.fire_event);
					error_count++;
				end
				void'(expected_events.pop_front());
			end
		end
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("tap_gesture_decoder_autorepeat_top_tb failed");
		$finish;
	end

	task automatic test_reset_gestures();
		send_sample(1'b0, 1'b0, 32'd1000);
		send_sample(1'b1, 1'b0, 32'd1000);
		send_sample(1'b0, 1'b0, 32'd1100);
		send_sample(1'b0, 1'b0, 32'd1300);
		send_sample(1'b0, 1'b0, 32'd1301);
		send_sample(1'b1, 1'b1, 32'd1400);
		send_sample(1'b0, 1'b1, 32'd1450);
		send_sample(1'b1, 1'b0, 32'd1500);
		send_sample(1'b1, 1'b0, 32'd1579);
		send_sample(1'b1, 1'b0, 32'd1580);
		send_sample(1'b0, 1'b0, 32'd1600);
		send_sample(1'b1, 1'b0, 32'd2000);
		send_sample(1'b1, 1'b0, 32'd2301);
		send_sample(1'b1, 1'b0, 32'd2381);
		send_sample(1'b0, 1'b0, 32'd2400);
		// A second tap that arrives late still counts when no sample closed the wait.
		send_sample(1'b1, 1'b0, 32'd3000);
		send_sample(1'b0, 1'b0, 32'd3000);
		send_sample(1'b1, 1'b0, 32'd5000);
		send_sample(1'b0, 1'b1, 32'd5001);
		// Timestamps wrap and may run backwards.
		send_sample(1'b1, 1'b0, 32'hFFFF_FFF0);
		send_sample(1'b0, 1'b0, 32'h0000_0010);
		send_sample(1'b0, 1'b0, 32'hFFFF_FF00);
		send_sample(1'b1, 1'b1, 32'h0000_0000);
		send_sample(1'b0, 1'b0, 32'h0000_012D);
		sample_time = 32'h0000_1000;
	endtask

	task automatic test_register_extremes();
		drain_events();
		write_register(REG_DOUBLE_TAP_WINDOW, '0);
		write_register(REG_REPEAT_PERIOD, '0);
		send_sample(1'b1, 1'b0, 32'd10000);
		send_sample(1'b1, 1'b0, 32'd10000);
		send_sample(1'b1, 1'b1, 32'd10001);
		send_sample(1'b1, 1'b1, 32'd10001);
		send_sample(1'b1, 1'b0, 32'd10001);
		send_sample(1'b0, 1'b0, 32'd10002);
		drain_events();
		write_register(REG_DOUBLE_TAP_WINDOW, '1);
		write_register(REG_REPEAT_PERIOD, '1);
		send_sample(1'b1, 1'b0, 32'd20000);
		send_sample(1'b1, 1'b0, 32'd20000 + 32'd65535);
		send_sample(1'b1, 1'b0, 32'd20000 + 32'd65536);
		send_sample(1'b1, 1'b0, 32'd20000 + 32'd131070);
		send_sample(1'b1, 1'b0, 32'd20000 + 32'd131071);
		send_sample(1'b0, 1'b0, 32'd20000 + 32'd131072);
		drain_events();
		write_register(REG_SPARE_LO, '0);
		write_register(REG_SPARE_HI, '0);
		send_sample(1'b1, 1'b0, 32'd300000);
		send_sample(1'b0, 1'b0, 32'd300000 + 32'd65535);
		send_sample(1'b0, 1'b0, 32'd300000 + 32'd65536);
		sample_time = 32'd400000;
	endtask

	task automatic test_backpressure();
		drain_events();
		write_register(REG_DOUBLE_TAP_WINDOW, WINDOW_RESET);
		write_register(REG_REPEAT_PERIOD, PERIOD_RESET);
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests <= hold_requests + 1;
		repeat (40) tick_sample(1'($urandom_range(1)), TIME_W'($urandom_range(0, 150)));
		drain_events();
	endtask

	task automatic run_random_gesture();
		int kind;
		int n;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2: begin
				tick_sample(1'b1, TIME_W'($urandom_range(0, 20)));
				n = $urandom_range(2);
				repeat (n) tick_sample(1'b1, TIME_W'($urandom_range(0, 5)));
				tick_sample(1'b0, TIME_W'($urandom_range(0, 5)));
				tick_sample(1'b0, near(TIME_W'(pred_window)));
				tick_sample(1'b0, TIME_W'($urandom_range(0, 3)));
			end
			3, 4, 5: begin
				tick_sample(1'b1, TIME_W'($urandom_range(0, 20)));
				tick_sample(1'b0, TIME_W'($urandom_range(0, 20)));
				tick_sample(1'b1, TIME_W'($urandom_range(0, pred_window)));
				n = $urandom_range(1, 8);
				repeat (n) tick_sample(1'b1, near(TIME_W'(pred_period)));
				tick_sample(1'b0, TIME_W'($urandom_range(0, 20)));
			end
			6, 7: begin
				tick_sample(1'b1, TIME_W'($urandom_range(0, 20)));
				tick_sample(1'b1, near(TIME_W'(pred_window)));
				n = $urandom_range(1, 8);
				repeat (n) begin
					if ($urandom_range(1))
						tick_sample(1'b1, near(TIME_W'(pred_period)));
					else
						tick_sample(1'b1, TIME_W'($urandom_range(0, 10)));
				end
				tick_sample(1'b0, TIME_W'($urandom_range(0, 20)));
			end
			8: begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					if ($urandom_range(3) == 0)
						tick_sample(1'($urandom_range(1)), TIME_W'($urandom));
					else
						tick_sample(1'($urandom_range(1)), TIME_W'($urandom_range(0, 400)));
				end
			end
			default: begin
				tick_sample(1'b1, TIME_W'($urandom));
				tick_sample(1'b0, TIME_W'($urandom));
				tick_sample(1'b1, TIME_W'($urandom_range(0, 400)));
				tick_sample(1'b1, TIME_W'($urandom));
				tick_sample(1'b0, TIME_W'($urandom_range(0, 50)));
			end
		endcase
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_mix, input int count);
		int target;
		drain_events();
		write_register(REG_DOUBLE_TAP_WINDOW, pick_setting());
		write_register(REG_REPEAT_PERIOD, pick_setting());
		send_idle_pct = idle_pct;
		stall_pct     = stall_mix;
		target        = items_sent + count;
		while (items_sent < target) run_random_gesture();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_gestures();
		test_register_extremes();
		test_backpressure();
		test_random_phase(0, 0, RANDOM_ITEMS / 4);
		test_random_phase(57, 0, RANDOM_ITEMS / 4);
		test_random_phase(0, 57, RANDOM_ITEMS / 4);
		test_random_phase(26, 26, RANDOM_ITEMS / 4);
		drain_events();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_events.size() != 0) begin
			$error("%0d expected output words never arrived", expected_events.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("tap_gesture_decoder_autorepeat_top_tb passed");
		end else begin
			$display("tap_gesture_decoder_autorepeat_top_tb failed");
		end
		$finish;
	end

endmodule
